/* src/tkcs_pkg.sv */
// Shared types and constants for the top-k by count selection block.
package tkcs_pkg;

  // Fixed field widths.
  localparam int KEY_W       = 48;
  localparam int COUNT_W     = 64;
  localparam int LIMIT_W     = 5;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

  // Input operation codes.
  typedef enum logic {
    OP_OFFER = 1'b0,
    OP_DRAIN = 1'b1
  } opcode_t;

  // Controller states.
  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_DRAIN = 1'b1
  } state_t;

  // Control broadcast from the controller to every cell.
  typedef struct packed {
    logic offer;        // an offer transaction is being applied this cycle
    logic shift_down;   // the chain moves one place toward cell 0
  } cell_ctrl_t;

endpackage

/* src/tkcs_cell.sv */
// One cell of the sorted chain: holds one (key, count) pair.
module tkcs_cell #(
  parameter int KW = 48
) (
  input  logic                        clk,
  input  tkcs_pkg::cell_ctrl_t        ctrl,
  input  logic                        occupied,
  input  logic                        allow,
  input  logic [KW-1:0]               new_key,
  input  logic [tkcs_pkg::COUNT_W-1:0] new_count,
  input  logic                        prev_take,
  input  logic [KW-1:0]               prev_key,
  input  logic [tkcs_pkg::COUNT_W-1:0] prev_count,
  input  logic [KW-1:0]               next_key,
  input  logic [tkcs_pkg::COUNT_W-1:0] next_count,
  output logic                        take,
  output logic [KW-1:0]               key,
  output logic [tkcs_pkg::COUNT_W-1:0] count
);
  import tkcs_pkg::*;

  // The offered pair belongs at or above this cell when the cell is empty or
  // holds a strictly smaller count, so it lands after all equal counts.
  assign take = !occupied || (new_count > count);

  // Load the new pair at the boundary, take the upper neighbor below it,
  // or take the lower neighbor while draining.
  always_ff @(posedge clk) begin
    if (ctrl.offer && allow && take) begin
      if (prev_take) begin
        key   <= prev_key;
        count <= prev_count;
      end else begin
        key   <= new_key;
        count <= new_count;
      end
    end else if (ctrl.shift_down) begin
      key   <= next_key;
      count <= next_count;
    end
  end

endmodule

/* src/top_k_by_count_select_core.sv */
// Top-k by count selection: controller, output register and the cell chain.
// An offer is applied to the chain at the edge that accepts it, one per cycle while idle.
// A drain of n held entries yields n results, one per cycle while the output is not
// stalled; the first is loaded from the drain state. An empty drain yields one result.
// The input stays stalled until the drain's last result is loaded into the output register.
// Synchronous reset empties the chain and sets the limit register to 16; no clearing pass.
module top_k_by_count_select_core #(
  parameter int CAPACITY  = 16,
  parameter int KEY_BYTES = 6
) (
  input  logic                          clk,
  input  logic                          rst,
  // Input channel.
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          opcode,
  input  logic [tkcs_pkg::KEY_W-1:0]    entry_key,
  input  logic [tkcs_pkg::COUNT_W-1:0]  entry_count,
  // Output channel.
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [tkcs_pkg::KEY_W-1:0]    result_key,
  output logic [tkcs_pkg::COUNT_W-1:0]  result_count,
  output logic                          result_valid,
  output logic                          last,
  // Configuration channel.
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tkcs_pkg::LIMIT_W-1:0]  keep_limit
);
  import tkcs_pkg::*;

  // Significant key bits, and widths for occupancy and limit compares.
  localparam int KW    = (8 * KEY_BYTES < KEY_W) ? 8 * KEY_BYTES : KEY_W;
  localparam int OCC_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (OCC_W > LIMIT_W) ? OCC_W : LIMIT_W;

  state_t               state, state_next;
  logic [LIMIT_W-1:0]   limit_value;
  logic [OCC_W-1:0]     occupancy;
  logic [LIMIT_W-1:0]   limit_raw;
  logic [CMP_W-1:0]     limit_eff;
  logic                 insert;
  logic [OCC_W-1:0]     bound;
  logic                 in_accept;
  logic                 slot_free;
  logic                 emit;
  cell_ctrl_t           ctrl;
  logic [KW-1:0]        new_key;

  logic [KW-1:0]        key_a   [CAPACITY];
  logic [COUNT_W-1:0]   count_a [CAPACITY];
  logic                 take_a  [CAPACITY];

  // The configuration register accepts a write in every cycle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit_value <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      limit_value <= keep_limit;
    end
  end

  // Effective limit: zero acts as one, and it never exceeds the capacity.
  always_comb begin
    limit_raw = (limit_value == '0) ? LIMIT_W'(1) : limit_value;
    limit_eff = (CMP_W'(limit_raw) > CMP_W'(CAPACITY)) ? CMP_W'(CAPACITY)
                                                        : CMP_W'(limit_raw);
  end

  // Insert grows the list by one; otherwise only held cells may change.
  assign insert = CMP_W'(occupancy) < limit_eff;
  assign bound  = insert ? occupancy + OCC_W'(1) : occupancy;

  // Handshake terms.
  assign in_accept = in_valid && !in_stall;
  assign slot_free = !out_valid || !out_stall;
  assign new_key   = entry_key[KW-1:0];

  // Next-state logic of the controller.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_accept && opcode == OP_DRAIN) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (slot_free && occupancy <= OCC_W'(1)) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Output logic of the controller.
  always_comb begin
    in_stall        = 1'b1;
    emit            = 1'b0;
    ctrl.offer      = 1'b0;
    ctrl.shift_down = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall   = 1'b0;
        ctrl.offer = in_accept && opcode == OP_OFFER;
      end
      ST_DRAIN: begin
        emit            = slot_free;
        ctrl.shift_down = slot_free && occupancy != '0;
      end
      default: in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Occupancy counts up on an insert and down on each drained entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy <= '0;
    end else if (ctrl.offer && insert) begin
      occupancy <= occupancy + OCC_W'(1);
    end else if (ctrl.shift_down) begin
      occupancy <= occupancy - OCC_W'(1);
    end
  end

  // The chain of cells, sorted by descending count from cell 0.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic               prev_take;
    logic [KW-1:0]      prev_key;
    logic [COUNT_W-1:0] prev_count;
    logic [KW-1:0]      next_key;
    logic [COUNT_W-1:0] next_count;

    if (i == 0) begin : g_first
      assign prev_take  = 1'b0;
      assign prev_key   = new_key;
      assign prev_count = entry_count;
    end else begin : g_inner
      assign prev_take  = take_a[i-1];
      assign prev_key   = key_a[i-1];
      assign prev_count = count_a[i-1];
    end

    if (i == CAPACITY - 1) begin : g_end
      assign next_key   = key_a[i];
      assign next_count = count_a[i];
    end else begin : g_mid
      assign next_key   = key_a[i+1];
      assign next_count = count_a[i+1];
    end

    tkcs_cell #(
      .KW(KW)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .occupied  (OCC_W'(i) < occupancy),
      .allow     (OCC_W'(i) < bound),
      .new_key   (new_key),
      .new_count (entry_count),
      .prev_take (prev_take),
      .prev_key  (prev_key),
      .prev_count(prev_count),
      .next_key  (next_key),
      .next_count(next_count),
      .take      (take_a[i]),
      .key       (key_a[i]),
      .count     (count_a[i])
    );
  end

  // Output register: valid flag under reset, payload loaded on each emit.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      if (occupancy == '0) begin
        // Empty drain: one invalid result that closes the run.
        result_key   <= '0;
        result_count <= '0;
        result_valid <= 1'b0;
        last         <= 1'b1;
      end else begin
        result_key   <= KEY_W'(key_a[0]);
        result_count <= count_a[0];
        result_valid <= 1'b1;
        last         <= (occupancy == OCC_W'(1));
      end
    end
  end

endmodule
